// ===== rtl/psc_pkg.sv =====
package psc_pkg;

    // Fraction bits of both results
    localparam int FRAC_BITS = 16;

    // Configuration port
    localparam int CFG_W = 48;
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TEMP_CAL = 2'd0;
    localparam t_cfg_idx REG_PRES_A   = 2'd1;
    localparam t_cfg_idx REG_PRES_B   = 2'd2;
    localparam t_cfg_idx REG_PRES_C   = 2'd3;

    // Temperature path
    localparam int T_W        = 29;              // Q16 temperature before clamping
    localparam int TEMP_SHIFT = 48 - FRAC_BITS;
    localparam logic [63:0] TEMP_POS_LIM = 64'd8388607;
    localparam logic [63:0] TEMP_NEG_LIM = 64'd8388608;
    localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TEMP_MIN = 24'sh800000;

    // Pressure scaling: divide the Q32 Pa sum by 100 * 2^(32-FRAC_BITS).
    // After a right shift by 34-FRAC_BITS only a division by 25 is left.
    localparam int PRES_SHIFT = 34 - FRAC_BITS;
    localparam logic [63:0] PRES_HALF  = 64'd50 << (32 - FRAC_BITS);
    localparam logic [63:0] PRES_LIMIT = 64'd25 << 27;
    localparam logic [32:0] RECIP_25   = 33'd5497558139;   // ceil(2^37 / 25)
    localparam int RECIP_SHIFT = 37;
    localparam logic [26:0] PRES_MAX   = 27'h7FFFFFF;

    // Multiply and round unit
    localparam int MUL_A_W  = 60;
    localparam int MUL_B_W  = 48;
    localparam int MUL_AH_W = MUL_A_W / 2;
    localparam int MUL_BH_W = MUL_B_W / 2;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int MUL_S_W  = 6;

    // Queue between the front and the back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [23:0] temperature_q16;
        logic [26:0]        pressure_hpa_q16;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_trim;

    typedef struct packed {
        logic signed [T_W-1:0] t_q16;
        logic signed [23:0]    temperature;
        logic                  temp_sat;
        logic [23:0]           raw_pressure;
    } t_fq;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Magnitude of a two's complement word
    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

// ===== rtl/pressure_sensor_compensation_top.sv =====
// Barometric sensor compensation.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction carries
// a raw 24-bit temperature and a raw 24-bit pressure conversion result.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transaction per
// input, in order, with the signed Q16 temperature in degrees Celsius, the
// unsigned Q16 pressure in hPa and a flag that marks a clamped result.
// Trim words are to be written through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle, not enforced by the block; writes take effect at once.
// Throughput is one transaction per cycle while the receiver does not stall.
// On its way to o_out_valid the transaction passes five front stages for the
// temperature polynomial, one queue slot, and sixteen back stages in which
// three levels of multiply-and-round units form the pressure polynomial,
// followed by the summation and the division by 100.
// A four-entry queue separates the front from the back. When the receiver
// stalls, the back pipeline holds as a whole, the queue fills, and then
// o_in_ready falls. Reset clears all pipeline valid bits, empties the queue
// and sets every trim register to zero.
module pressure_sensor_compensation_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  psc_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output psc_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  psc_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [psc_pkg::CFG_W-1:0] i_cfg_data
);

    logic [39:0] r_cal_t;
    logic [47:0] r_cal_a;
    logic [47:0] r_cal_b;
    logic [31:0] r_cal_c;

    psc_pkg::t_trim   w_trim;
    psc_pkg::t_q_stat w_q_stat;
    psc_pkg::t_fq     w_push_data, w_pop_data;
    logic             w_push, w_pop;

    // Calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psc_pkg::REG_TEMP_CAL: r_cal_t <= i_cfg_data[39:0];
                psc_pkg::REG_PRES_A:   r_cal_a <= i_cfg_data[47:0];
                psc_pkg::REG_PRES_B:   r_cal_b <= i_cfg_data[47:0];
                psc_pkg::REG_PRES_C:   r_cal_c <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Unpack the trim words
    assign w_trim.t1  = r_cal_t[15:0];
    assign w_trim.t2  = r_cal_t[31:16];
    assign w_trim.t3  = $signed(r_cal_t[39:32]);
    assign w_trim.p1  = $signed(r_cal_a[15:0]);
    assign w_trim.p2  = $signed(r_cal_a[31:16]);
    assign w_trim.p3  = $signed(r_cal_a[39:32]);
    assign w_trim.p4  = $signed(r_cal_a[47:40]);
    assign w_trim.p5  = r_cal_b[15:0];
    assign w_trim.p6  = r_cal_b[31:16];
    assign w_trim.p7  = $signed(r_cal_b[39:32]);
    assign w_trim.p8  = $signed(r_cal_b[47:40]);
    assign w_trim.p9  = $signed(r_cal_c[15:0]);
    assign w_trim.p10 = $signed(r_cal_c[23:16]);
    assign w_trim.p11 = $signed(r_cal_c[31:24]);

    psc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_trim      (w_trim),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    psc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    psc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trim      (w_trim),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_q_data    (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/psc_mul.sv =====
module psc_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [psc_pkg::MUL_A_W-1:0]       i_a,
    input  logic [psc_pkg::MUL_B_W-1:0]       i_b,
    input  logic                              i_neg,
    input  logic [psc_pkg::MUL_S_W-1:0]       i_shift,
    output logic signed [63:0]                o_res
);

    localparam int AH = psc_pkg::MUL_AH_W;
    localparam int BH = psc_pkg::MUL_BH_W;
    localparam int PW = AH + BH;
    localparam int SW = psc_pkg::MUL_P_W;
    localparam logic [psc_pkg::MUL_S_W-1:0] S_ONE = {{(psc_pkg::MUL_S_W-1){1'b0}}, 1'b1};

    logic [PW-1:0] r_pp00, r_pp01, r_pp10, r_pp11;
    logic          r_neg1, r_neg2;
    logic [SW-1:0] r_sum, n_sum, w_half, w_shifted;
    logic [61:0]   w_mag;
    logic signed [63:0] r_res, n_res;

    // Rounding constant: half of the last kept bit, none for an exact product
    assign w_half = (i_shift == '0) ? '0 : (SW'(1) << (i_shift - S_ONE));

    // Sum of the four partial products plus the rounding constant
    assign n_sum = SW'(r_pp00) + (SW'(r_pp01) << BH) + (SW'(r_pp10) << AH)
                 + (SW'(r_pp11) << (AH + BH)) + w_half;

    // Shift, clamp to 62 bits and apply the sign
    assign w_shifted = r_sum >> i_shift;
    assign w_mag     = (|w_shifted[SW-1:62]) ? '1 : w_shifted[61:0];
    assign n_res     = r_neg2 ? (64'sd0 - $signed({2'b00, w_mag})) : $signed({2'b00, w_mag});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00 <= PW'(i_a[AH-1:0]) * PW'(i_b[BH-1:0]);
            r_pp01 <= PW'(i_a[AH-1:0]) * PW'(i_b[2*BH-1:BH]);
            r_pp10 <= PW'(i_a[2*AH-1:AH]) * PW'(i_b[BH-1:0]);
            r_pp11 <= PW'(i_a[2*AH-1:AH]) * PW'(i_b[2*BH-1:BH]);
            r_neg1 <= i_neg;
            r_sum  <= n_sum;
            r_neg2 <= r_neg1;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/psc_front.sv =====
module psc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  psc_pkg::t_in    i_in_data,
    input  psc_pkg::t_trim  i_trim,
    input  psc_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output psc_pkg::t_fq    o_push_data
);

    localparam int TW = psc_pkg::T_W;

    logic [4:0]          r_v;
    logic                w_en;
    logic [23:0]         r_rt;
    logic [23:0]         r_u0, r_u1, r_u2, r_u3, r_u4;
    logic signed [25:0]  r_d;
    logic signed [42:0]  r_dt2;
    logic signed [51:0]  r_dd;
    logic signed [59:0]  w_ddt3;
    logic signed [63:0]  r_t48, n_t48;
    logic [63:0]         w_mag, w_t_mag, w_temp_mag, w_t_signed;
    logic signed [TW-1:0] r_t, n_t;
    logic signed [23:0]  r_temp, n_temp;
    logic                r_tsat, n_tsat;

    // The front advances unless its last stage waits on a full queue
    assign w_en       = !r_v[4] || !i_q_stat.full;
    assign o_in_ready = w_en;
    assign o_push     = r_v[4] && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_in_valid};
        end
    end

    // Second-order temperature polynomial, exact in Q48
    assign w_ddt3 = r_dd * i_trim.t3;
    assign n_t48  = (64'(r_dt2) <<< 18) + 64'(w_ddt3);

    // Rounding to Q16 for the pressure path and to the output scaling
    assign w_mag      = psc_pkg::mag64(r_t48);
    assign w_t_mag    = (w_mag + 64'h8000_0000) >> 32;
    assign w_temp_mag = (w_mag + (64'd1 << (psc_pkg::TEMP_SHIFT - 1))) >> psc_pkg::TEMP_SHIFT;
    assign w_t_signed = r_t48[63] ? (64'd0 - w_t_mag) : w_t_mag;
    assign n_t        = w_t_signed[TW-1:0];

    // Temperature clamping
    always_comb begin
        n_tsat = 1'b0;
        if (r_t48[63]) begin
            if (w_temp_mag > psc_pkg::TEMP_NEG_LIM) begin
                n_temp = psc_pkg::TEMP_MIN;
                n_tsat = 1'b1;
            end else begin
                n_temp = 24'(64'd0 - w_temp_mag);
            end
        end else begin
            if (w_temp_mag > psc_pkg::TEMP_POS_LIM) begin
                n_temp = psc_pkg::TEMP_MAX;
                n_tsat = 1'b1;
            end else begin
                n_temp = w_temp_mag[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rt   <= i_in_data.raw_temperature;
            r_u0   <= i_in_data.raw_pressure;
            r_d    <= $signed({2'b00, r_rt}) - $signed({2'b00, i_trim.t1, 8'h00});
            r_u1   <= r_u0;
            r_dt2  <= 43'(r_d) * 43'($signed({1'b0, i_trim.t2}));
            r_dd   <= 52'(r_d) * 52'(r_d);
            r_u2   <= r_u1;
            r_t48  <= n_t48;
            r_u3   <= r_u2;
            r_t    <= n_t;
            r_temp <= n_temp;
            r_tsat <= n_tsat;
            r_u4   <= r_u3;
        end
    end

    assign o_push_data.t_q16        = r_t;
    assign o_push_data.temperature  = r_temp;
    assign o_push_data.temp_sat     = r_tsat;
    assign o_push_data.raw_pressure = r_u4;

endmodule

// ===== rtl/psc_queue.sv =====
module psc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  psc_pkg::t_fq     i_push_data,
    input  logic             i_pop,
    output psc_pkg::t_fq     o_pop_data,
    output psc_pkg::t_q_stat o_stat
);

    localparam int AW = psc_pkg::Q_AW;

    psc_pkg::t_fq  r_mem [psc_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (AW + 1)'(psc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/psc_back.sv =====
module psc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psc_pkg::t_trim   i_trim,
    input  psc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    input  psc_pkg::t_fq     i_q_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output psc_pkg::t_out    o_out_data
);

    localparam int NSTG = 16;
    localparam int TW   = psc_pkg::T_W;
    localparam int AW   = psc_pkg::MUL_A_W;
    localparam int BW   = psc_pkg::MUL_B_W;
    localparam int SW   = psc_pkg::MUL_S_W;

    logic [NSTG-1:0]     r_v;
    logic                w_en, w_pop;

    // Delay lines for values used further down the pipeline
    logic signed [TW-1:0] r_t_d    [4];
    logic [23:0]          r_u_d    [7];
    logic signed [23:0]   r_temp_d [NSTG-1];
    logic                 r_sat_d  [NSTG-1];
    logic signed [63:0]   r_up4_d  [3];

    // Trim magnitudes
    logic signed [63:0] w_p1x, w_p2x;
    logic [63:0] w_p1m, w_p2m, w_p3m, w_p4m, w_p7m, w_p8m, w_p9m, w_p10m, w_p11m;
    logic [63:0] w_ta_mag, w_tb_mag;

    // Product results
    logic signed [63:0] w_t2, w_u2, w_p6t, w_e0, w_up2, w_up3, w_up4, w_p10t;
    logic signed [63:0] w_t3, w_c, w_f, w_g, w_i, w_j, w_p11u2;
    logic signed [63:0] w_d, w_h, w_k;
    logic [63:0] w_up2m, w_up3m, w_p10tm, w_t3m, w_up4m, w_p11u2m;

    // Accumulation and scaling
    logic signed [63:0] r_sab, r_se, r_s1, r_s1d, r_x1, r_x2, r_x3;
    logic signed [63:0] r_y1, r_y2, r_z, r_w1, r_w2, r_acc;
    logic [63:0]        r_x, w_zf;
    logic [31:0]        r_z32;
    logic [64:0]        r_prod;
    logic               r_pneg12, r_pneg13, r_pneg14;
    logic               r_psat13, r_psat14;
    psc_pkg::t_out      r_out, n_out;

    // The whole back pipeline moves when its output register is free
    assign w_en        = !r_v[NSTG-1] || i_out_ready;
    assign w_pop       = w_en && !i_q_stat.empty;
    assign o_pop       = w_pop;
    assign o_out_valid = r_v[NSTG-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0], w_pop};
        end
    end

    assign w_p1x  = 64'(i_trim.p1) - 64'sd16384;
    assign w_p2x  = 64'(i_trim.p2) - 64'sd16384;
    assign w_p1m  = psc_pkg::mag64(w_p1x);
    assign w_p2m  = psc_pkg::mag64(w_p2x);
    assign w_p3m  = psc_pkg::mag64(64'(i_trim.p3));
    assign w_p4m  = psc_pkg::mag64(64'(i_trim.p4));
    assign w_p7m  = psc_pkg::mag64(64'(i_trim.p7));
    assign w_p8m  = psc_pkg::mag64(64'(i_trim.p8));
    assign w_p9m  = psc_pkg::mag64(64'(i_trim.p9));
    assign w_p10m = psc_pkg::mag64(64'(i_trim.p10));
    assign w_p11m = psc_pkg::mag64(64'(i_trim.p11));
    assign w_ta_mag = psc_pkg::mag64(64'(r_t_d[0]));
    assign w_tb_mag = psc_pkg::mag64(64'(r_t_d[3]));

    // First level: squares and products of readings with trims
    psc_mul u_mul_t2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_ta_mag[AW-1:0]),
        .i_b(w_ta_mag[BW-1:0]), .i_neg(1'b0), .i_shift(SW'(0)), .o_res(w_t2));
    psc_mul u_mul_u2 (.i_clk(i_clk), .i_en(w_en), .i_a(AW'(r_u_d[0])),
        .i_b(BW'(r_u_d[0])), .i_neg(1'b0), .i_shift(SW'(0)), .o_res(w_u2));
    psc_mul u_mul_p6t (.i_clk(i_clk), .i_en(w_en), .i_a(w_ta_mag[AW-1:0]),
        .i_b(BW'(i_trim.p6)), .i_neg(r_t_d[0][TW-1]), .i_shift(SW'(0)), .o_res(w_p6t));
    psc_mul u_mul_e0 (.i_clk(i_clk), .i_en(w_en), .i_a(AW'(r_u_d[0])),
        .i_b(w_p1m[BW-1:0]), .i_neg(w_p1x[63]), .i_shift(SW'(0)), .o_res(w_e0));
    psc_mul u_mul_up2 (.i_clk(i_clk), .i_en(w_en), .i_a(AW'(r_u_d[0])),
        .i_b(w_p2m[BW-1:0]), .i_neg(w_p2x[63]), .i_shift(SW'(0)), .o_res(w_up2));
    psc_mul u_mul_up3 (.i_clk(i_clk), .i_en(w_en), .i_a(AW'(r_u_d[0])),
        .i_b(w_p3m[BW-1:0]), .i_neg(i_trim.p3[7]), .i_shift(SW'(0)), .o_res(w_up3));
    psc_mul u_mul_up4 (.i_clk(i_clk), .i_en(w_en), .i_a(AW'(r_u_d[0])),
        .i_b(w_p4m[BW-1:0]), .i_neg(i_trim.p4[7]), .i_shift(SW'(0)), .o_res(w_up4));
    psc_mul u_mul_p10t (.i_clk(i_clk), .i_en(w_en), .i_a(w_ta_mag[AW-1:0]),
        .i_b(w_p10m[BW-1:0]), .i_neg(r_t_d[0][TW-1] ^ i_trim.p10[7]),
        .i_shift(SW'(0)), .o_res(w_p10t));

    assign w_up2m  = psc_pkg::mag64(w_up2);
    assign w_up3m  = psc_pkg::mag64(w_up3);
    assign w_p10tm = psc_pkg::mag64(w_p10t);

    // Second level: cube of the temperature and most of the pressure terms
    psc_mul u_mul_t3 (.i_clk(i_clk), .i_en(w_en), .i_a(w_t2[AW-1:0]),
        .i_b(w_tb_mag[BW-1:0]), .i_neg(r_t_d[3][TW-1]), .i_shift(SW'(24)), .o_res(w_t3));
    psc_mul u_mul_c (.i_clk(i_clk), .i_en(w_en), .i_a(w_t2[AW-1:0]),
        .i_b(w_p7m[BW-1:0]), .i_neg(i_trim.p7[7]), .i_shift(SW'(8)), .o_res(w_c));
    psc_mul u_mul_f (.i_clk(i_clk), .i_en(w_en), .i_a(w_up2m[AW-1:0]),
        .i_b(w_tb_mag[BW-1:0]), .i_neg(w_up2[63] ^ r_t_d[3][TW-1]),
        .i_shift(SW'(13)), .o_res(w_f));
    psc_mul u_mul_g (.i_clk(i_clk), .i_en(w_en), .i_a(w_t2[AW-1:0]),
        .i_b(w_up3m[BW-1:0]), .i_neg(w_up3[63]), .i_shift(SW'(32)), .o_res(w_g));
    psc_mul u_mul_i (.i_clk(i_clk), .i_en(w_en), .i_a(w_u2[AW-1:0]),
        .i_b(w_p9m[BW-1:0]), .i_neg(i_trim.p9[15]), .i_shift(SW'(16)), .o_res(w_i));
    psc_mul u_mul_j (.i_clk(i_clk), .i_en(w_en), .i_a(w_p10tm[AW-1:0]),
        .i_b(w_u2[BW-1:0]), .i_neg(w_p10t[63]), .i_shift(SW'(32)), .o_res(w_j));
    psc_mul u_mul_p11u2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_u2[AW-1:0]),
        .i_b(w_p11m[BW-1:0]), .i_neg(i_trim.p11[7]), .i_shift(SW'(0)), .o_res(w_p11u2));

    assign w_t3m    = psc_pkg::mag64(w_t3);
    assign w_up4m   = psc_pkg::mag64(r_up4_d[2]);
    assign w_p11u2m = psc_pkg::mag64(w_p11u2);

    // Third level: terms in the cube of the temperature and the cube of the pressure
    psc_mul u_mul_d (.i_clk(i_clk), .i_en(w_en), .i_a(w_t3m[AW-1:0]),
        .i_b(w_p8m[BW-1:0]), .i_neg(w_t3[63] ^ i_trim.p8[7]), .i_shift(SW'(7)), .o_res(w_d));
    psc_mul u_mul_h (.i_clk(i_clk), .i_en(w_en), .i_a(w_t3m[AW-1:0]),
        .i_b(w_up4m[BW-1:0]), .i_neg(w_t3[63] ^ r_up4_d[2][63]),
        .i_shift(SW'(29)), .o_res(w_h));
    psc_mul u_mul_k (.i_clk(i_clk), .i_en(w_en), .i_a(w_p11u2m[AW-1:0]),
        .i_b(BW'(r_u_d[6])), .i_neg(w_p11u2[63]), .i_shift(SW'(33)), .o_res(w_k));

    // Pressure scaling: shift away the power of two, then divide by 25
    assign w_zf = r_x >> psc_pkg::PRES_SHIFT;

    // Output word
    always_comb begin
        n_out.temperature_q16 = r_temp_d[NSTG-2];
        if (r_pneg14) begin
            n_out.pressure_hpa_q16 = '0;
        end else if (r_psat14) begin
            n_out.pressure_hpa_q16 = psc_pkg::PRES_MAX;
        end else begin
            n_out.pressure_hpa_q16 = r_prod[psc_pkg::RECIP_SHIFT+26:psc_pkg::RECIP_SHIFT];
        end
        n_out.saturated = r_sat_d[NSTG-2] | r_pneg14 | r_psat14;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_d[0]    <= i_q_data.t_q16;
            r_u_d[0]    <= i_q_data.raw_pressure;
            r_temp_d[0] <= i_q_data.temperature;
            r_sat_d[0]  <= i_q_data.temp_sat;
            for (int k = 1; k < 4; k++) begin
                r_t_d[k] <= r_t_d[k-1];
            end
            for (int k = 1; k < 7; k++) begin
                r_u_d[k] <= r_u_d[k-1];
            end
            for (int k = 1; k < NSTG - 1; k++) begin
                r_temp_d[k] <= r_temp_d[k-1];
                r_sat_d[k]  <= r_sat_d[k-1];
            end
            r_up4_d[0] <= w_up4;
            r_up4_d[1] <= r_up4_d[0];
            r_up4_d[2] <= r_up4_d[1];

            // Partial sums while the later products are formed
            r_sab <= $signed(64'(i_trim.p5) << 35) + (w_p6t <<< 10);
            r_se  <= w_e0 <<< 12;
            r_s1  <= r_sab + r_se;
            r_s1d <= r_s1;
            r_x1  <= r_s1d + w_c;
            r_x2  <= w_f + w_g;
            r_x3  <= w_i + w_j;
            r_y1  <= r_x1 + r_x2;
            r_y2  <= r_x3;
            r_z   <= r_y1 + r_y2;
            r_w1  <= r_z + w_d;
            r_w2  <= w_h + w_k;
            r_acc <= r_w1 + r_w2;

            // Division by 100 with rounding, and the range checks
            r_pneg12 <= r_acc[63];
            r_x      <= r_acc + psc_pkg::PRES_HALF;
            r_pneg13 <= r_pneg12;
            r_psat13 <= (w_zf >= psc_pkg::PRES_LIMIT);
            r_z32    <= w_zf[31:0];
            r_pneg14 <= r_pneg13;
            r_psat14 <= r_psat13;
            r_prod   <= 65'(r_z32) * 65'(psc_pkg::RECIP_25);
            r_out    <= n_out;
        end
    end

endmodule

// ===== rtl/psc_checker.sv =====
module psc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input psc_pkg::t_in              i_in_data,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input psc_pkg::t_out             o_out_data,
    input logic                      i_cfg_we,
    input psc_pkg::t_cfg_idx         i_cfg_idx,
    input logic [psc_pkg::CFG_W-1:0] i_cfg_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // Reset leaves the input side open
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready straight after reset");

endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (.*);
